// File: sv/bbt_pkg.sv
// Shared types, constants and helpers for the pixel bounding-box trim block.
// Used by every module of the block; no dependencies.
`default_nettype none

package bbt_pkg;

    localparam int MAX_DIM = 4096;
    localparam int POS_W   = $clog2(MAX_DIM);
    localparam int DIM_W   = POS_W + 1;
    localparam int PIX_W   = 32;
    localparam int FMT_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [FMT_W-1:0] FMT_RGBA       = 2'd0;
    localparam logic [FMT_W-1:0] FMT_GRAY_ALPHA = 2'd1;
    localparam logic [FMT_W-1:0] FMT_INDEXED    = 2'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FORMAT = 2'd0,
        REG_REF    = 2'd1,
        REG_WIDTH  = 2'd2,
        REG_HEIGHT = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [FMT_W-1:0] fmt;
        logic [PIX_W-1:0] ref_pix;
        logic [DIM_W-1:0] width;   // clamped
        logic [DIM_W-1:0] height;  // clamped
    } cfg_t;

    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic [POS_W-1:0] col;
        logic [POS_W-1:0] row;
        logic             last;
    } item_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0)
            r = DIM_W'(1);
        else if (v > DIM_W'(MAX_DIM))
            r = DIM_W'(MAX_DIM);
        else
            r = v;
        return r;
    endfunction

    function automatic logic matches_ref(input logic [FMT_W-1:0] fmt,
                                         input logic [PIX_W-1:0] p,
                                         input logic [PIX_W-1:0] r);
        logic both_clear;
        both_clear = 1'b0;
        if (fmt == FMT_RGBA)
            both_clear = (p[31:24] == 8'd0) && (r[31:24] == 8'd0);
        else if (fmt == FMT_GRAY_ALPHA)
            both_clear = (p[15:8] == 8'd0) && (r[15:8] == 8'd0);
        return both_clear || (p == r);
    endfunction

endpackage

`default_nettype wire

// File: sv/bbt_cfg.sv
// Configuration registers of the bounding-box trim block, with dimension clamping.
// Depends on bbt_pkg.
`default_nettype none

module bbt_cfg
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [bbt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [bbt_pkg::CFG_DATA_W-1:0]  cfg_data,
    output bbt_pkg::cfg_t                        cfg
);

    logic [bbt_pkg::FMT_W-1:0] fmt_reg;
    logic [bbt_pkg::PIX_W-1:0] ref_reg;
    logic [bbt_pkg::DIM_W-1:0] width_reg;
    logic [bbt_pkg::DIM_W-1:0] height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg    <= bbt_pkg::FMT_RGBA;
            ref_reg    <= '0;
            width_reg  <= bbt_pkg::DIM_W'(1);
            height_reg <= bbt_pkg::DIM_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (bbt_pkg::cfg_reg_t'(cfg_index))
                bbt_pkg::REG_FORMAT: fmt_reg    <= cfg_data[bbt_pkg::FMT_W-1:0];
                bbt_pkg::REG_REF:    ref_reg    <= cfg_data[bbt_pkg::PIX_W-1:0];
                bbt_pkg::REG_WIDTH:  width_reg  <= cfg_data[bbt_pkg::DIM_W-1:0];
                bbt_pkg::REG_HEIGHT: height_reg <= cfg_data[bbt_pkg::DIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        cfg.fmt     = fmt_reg;
        cfg.ref_pix = ref_reg;
        cfg.width   = bbt_pkg::clamp_dim(width_reg);
        cfg.height  = bbt_pkg::clamp_dim(height_reg);
    end

endmodule

`default_nettype wire

// File: sv/bbt_scan.sv
// Raster position counter and input register: tags each pixel with column, row, last.
// Depends on bbt_pkg.
`default_nettype none

module bbt_scan
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  bbt_pkg::cfg_t                    cfg,
    input  wire logic                        pixel_valid,
    output logic                             pixel_stall,
    input  wire logic [bbt_pkg::PIX_W-1:0]   pixel,
    input  wire logic                        acc_ready,
    output logic                             item_valid,
    output bbt_pkg::item_t                   item
);

    logic [bbt_pkg::POS_W-1:0] col_reg, col_next;
    logic [bbt_pkg::POS_W-1:0] row_reg, row_next;
    logic                      valid_reg, valid_next;
    bbt_pkg::item_t            item_reg, item_next;
    logic                      advance;
    logic                      accept;
    logic                      row_end;
    logic                      img_end;

    assign advance     = !valid_reg || acc_ready;
    assign pixel_stall = !advance;
    assign accept      = pixel_valid && advance;

    assign row_end = ({1'b0, col_reg} + bbt_pkg::DIM_W'(1)) >= cfg.width;
    assign img_end = ({1'b0, row_reg} + bbt_pkg::DIM_W'(1)) >= cfg.height;

    always_comb
    begin
        col_next   = col_reg;
        row_next   = row_reg;
        valid_next = valid_reg;
        item_next  = item_reg;
        if (advance)
            valid_next = pixel_valid;
        if (accept)
        begin
            item_next.pix  = pixel;
            item_next.col  = col_reg;
            item_next.row  = row_reg;
            item_next.last = row_end && img_end;
            if (!row_end)
            begin
                col_next = col_reg + bbt_pkg::POS_W'(1);
            end
            else if (!img_end)
            begin
                col_next = '0;
                row_next = row_reg + bbt_pkg::POS_W'(1);
            end
            else
            begin
                col_next = '0;
                row_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

// File: sv/bbt_acc.sv
// Background compare, running min/max bounds and the result register.
// Depends on bbt_pkg.
`default_nettype none

module bbt_acc
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  bbt_pkg::cfg_t                    cfg,
    input  wire logic                        item_valid,
    input  bbt_pkg::item_t                   item,
    output logic                             acc_ready,
    output logic                             box_valid,
    input  wire logic                        box_stall,
    output logic [bbt_pkg::DIM_W-1:0]        box_x,
    output logic [bbt_pkg::DIM_W-1:0]        box_y,
    output logic [bbt_pkg::DIM_W-1:0]        box_w,
    output logic [bbt_pkg::DIM_W-1:0]        box_h,
    output logic                             nonempty
);

    logic [bbt_pkg::POS_W-1:0] min_col_reg, min_col_next;
    logic [bbt_pkg::POS_W-1:0] max_col_reg, max_col_next;
    logic [bbt_pkg::POS_W-1:0] min_row_reg, min_row_next;
    logic [bbt_pkg::POS_W-1:0] max_row_reg, max_row_next;
    logic                      seen_reg, seen_next;
    logic                      out_valid_reg, out_valid_next;
    logic [bbt_pkg::DIM_W-1:0] x_reg, x_next;
    logic [bbt_pkg::DIM_W-1:0] y_reg, y_next;
    logic [bbt_pkg::DIM_W-1:0] w_reg, w_next;
    logic [bbt_pkg::DIM_W-1:0] h_reg, h_next;
    logic                      ne_reg, ne_next;
    logic                      fire;
    logic                      diff;
    logic [bbt_pkg::POS_W-1:0] upd_min_col, upd_max_col;
    logic [bbt_pkg::POS_W-1:0] upd_min_row, upd_max_row;
    logic                      upd_seen;

    assign acc_ready = !(item.last && out_valid_reg && box_stall);
    assign fire      = item_valid && acc_ready;
    assign diff      = !bbt_pkg::matches_ref(cfg.fmt, item.pix, cfg.ref_pix);

    always_comb
    begin
        upd_min_col = min_col_reg;
        upd_max_col = max_col_reg;
        upd_min_row = min_row_reg;
        upd_max_row = max_row_reg;
        upd_seen    = seen_reg;
        if (diff)
        begin
            if (item.col < min_col_reg) upd_min_col = item.col;
            if (item.col > max_col_reg) upd_max_col = item.col;
            if (item.row < min_row_reg) upd_min_row = item.row;
            if (item.row > max_row_reg) upd_max_row = item.row;
            upd_seen = 1'b1;
        end
    end

    always_comb
    begin
        min_col_next   = min_col_reg;
        max_col_next   = max_col_reg;
        min_row_next   = min_row_reg;
        max_row_next   = max_row_reg;
        seen_next      = seen_reg;
        out_valid_next = out_valid_reg && box_stall;
        x_next         = x_reg;
        y_next         = y_reg;
        w_next         = w_reg;
        h_next         = h_reg;
        ne_next        = ne_reg;
        if (fire)
        begin
            if (item.last)
            begin
                min_col_next   = '1;
                max_col_next   = '0;
                min_row_next   = '1;
                max_row_next   = '0;
                seen_next      = 1'b0;
                out_valid_next = 1'b1;
                ne_next        = upd_seen;
                if (upd_seen)
                begin
                    x_next = {1'b0, upd_min_col};
                    y_next = {1'b0, upd_min_row};
                    w_next = {1'b0, upd_max_col} - {1'b0, upd_min_col}
                             + bbt_pkg::DIM_W'(1);
                    h_next = {1'b0, upd_max_row} - {1'b0, upd_min_row}
                             + bbt_pkg::DIM_W'(1);
                end
                else
                begin
                    x_next = cfg.width;
                    y_next = cfg.height;
                    w_next = '0;
                    h_next = '0;
                end
            end
            else
            begin
                min_col_next = upd_min_col;
                max_col_next = upd_max_col;
                min_row_next = upd_min_row;
                max_row_next = upd_max_row;
                seen_next    = upd_seen;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_col_reg   <= '1;
            max_col_reg   <= '0;
            min_row_reg   <= '1;
            max_row_reg   <= '0;
            seen_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            min_col_reg   <= min_col_next;
            max_col_reg   <= max_col_next;
            min_row_reg   <= min_row_next;
            max_row_reg   <= max_row_next;
            seen_reg      <= seen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg  <= x_next;
        y_reg  <= y_next;
        w_reg  <= w_next;
        h_reg  <= h_next;
        ne_reg <= ne_next;
    end

    assign box_valid = out_valid_reg;
    assign box_x     = x_reg;
    assign box_y     = y_reg;
    assign box_w     = w_reg;
    assign box_h     = h_reg;
    assign nonempty  = ne_reg;

    // end of image always leaves the bounds cleared
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && item.last) |=> (!seen_reg && max_col_reg == '0 && max_row_reg == '0))
        else $error("bounds not cleared after end of image");

    a_bounds_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg |-> (min_col_reg <= max_col_reg && min_row_reg <= max_row_reg))
        else $error("bounds out of order");

    a_nonempty_size: assert property (@(posedge clk) disable iff (!rst_n)
        (box_valid && nonempty) |-> (box_w != '0 && box_h != '0))
        else $error("nonempty box with zero size");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (box_valid && box_stall) |-> !(fire && item.last))
        else $error("result overwritten while stalled");

endmodule

`default_nettype wire

// File: sv/pixel_bounding_box_trim_top.sv
// Top level of the pixel bounding-box trim block.
// Depends on bbt_pkg, bbt_cfg, bbt_scan and bbt_acc.
//
//  Channel  Handshake                Payload
//  -------  -----------------------  -------------------------------------
//  pixel    pixel_valid/pixel_stall  pixel[31:0]
//  box      box_valid/box_stall      box_x, box_y, box_w, box_h, nonempty
//  cfg      cfg_we                   cfg_index[1:0], cfg_data[31:0]
//
//  One pixel per clock while pixel_stall is low. The last pixel's transaction reaches box_valid
//  through the input register, then compare/min-max logic into the result register.
//  Reset clears the scan position, bounds and configuration; no clearing pass.
//  pixel_stall rises only when a last pixel waits behind a result still held by box_stall.
`default_nettype none

module pixel_bounding_box_trim_top
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [bbt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [bbt_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                            pixel_valid,
    output logic                                 pixel_stall,
    input  wire logic [bbt_pkg::PIX_W-1:0]       pixel,
    output logic                                 box_valid,
    input  wire logic                            box_stall,
    output logic [bbt_pkg::DIM_W-1:0]            box_x,
    output logic [bbt_pkg::DIM_W-1:0]            box_y,
    output logic [bbt_pkg::DIM_W-1:0]            box_w,
    output logic [bbt_pkg::DIM_W-1:0]            box_h,
    output logic                                 nonempty
);

    bbt_pkg::cfg_t  cfg;
    bbt_pkg::item_t item;
    logic           item_valid;
    logic           acc_ready;

    bbt_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bbt_scan u_scan
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .pixel       (pixel),
        .acc_ready   (acc_ready),
        .item_valid  (item_valid),
        .item        (item)
    );

    bbt_acc u_acc
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item       (item),
        .acc_ready  (acc_ready),
        .box_valid  (box_valid),
        .box_stall  (box_stall),
        .box_x      (box_x),
        .box_y      (box_y),
        .box_w      (box_w),
        .box_h      (box_h),
        .nonempty   (nonempty)
    );

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
// Self-checking bench for pixel_bounding_box_trim_top: it streams images and
// predicts each trimmed box. Depends on bbt_pkg and the block's RTL only.

module tb;

    localparam logic [bbt_pkg::FMT_W-1:0] FMT_UNUSED = 2'd3;
    localparam int unsigned DRAIN = 4;
    localparam int unsigned WATCHDOG_LIMIT = 1000;
    localparam int unsigned RANDOM_PIXELS = 1500;

    typedef struct packed {
        logic [bbt_pkg::DIM_W-1:0] x;
        logic [bbt_pkg::DIM_W-1:0] y;
        logic [bbt_pkg::DIM_W-1:0] w;
        logic [bbt_pkg::DIM_W-1:0] h;
        logic                      ne;
    } box_t;

    class bounds_tracker;
        logic [bbt_pkg::FMT_W-1:0] fmt;
        logic [bbt_pkg::PIX_W-1:0] bg;
        logic [bbt_pkg::DIM_W-1:0] width_reg;
        logic [bbt_pkg::DIM_W-1:0] height_reg;
        int unsigned col;
        int unsigned row;
        int unsigned min_c;
        int unsigned max_c;
        int unsigned min_r;
        int unsigned max_r;
        bit seen;
        box_t boxes_due[$];
        int errors;

        function new();
            fmt = bbt_pkg::FMT_RGBA;
            bg = '0;
            width_reg = bbt_pkg::DIM_W'(1);
            height_reg = bbt_pkg::DIM_W'(1);
            errors = 0;
            restart_image();
        endfunction

        static function int unsigned eff_dim(logic [bbt_pkg::DIM_W-1:0] v);
            if (v == 0)
                return 1;
            if (v > bbt_pkg::MAX_DIM)
                return bbt_pkg::MAX_DIM;
            return 32'(v);
        endfunction

        function void restart_image();
            col = 0;
            row = 0;
            min_c = 32'hFFFF_FFFF;
            max_c = 0;
            min_r = 32'hFFFF_FFFF;
            max_r = 0;
            seen = 1'b0;
        endfunction

        function void write_reg(bbt_pkg::cfg_reg_t idx, logic [bbt_pkg::CFG_DATA_W-1:0] d);
            case (idx)
                bbt_pkg::REG_FORMAT: fmt = d[bbt_pkg::FMT_W-1:0];
                bbt_pkg::REG_REF:    bg = d;
                bbt_pkg::REG_WIDTH:  width_reg = d[bbt_pkg::DIM_W-1:0];
                bbt_pkg::REG_HEIGHT: height_reg = d[bbt_pkg::DIM_W-1:0];
                default: ;
            endcase
        endfunction

        function void take_pixel(logic [bbt_pkg::PIX_W-1:0] p);
            int unsigned w;
            int unsigned h;
            bit same;
            box_t b;
            w = eff_dim(width_reg);
            h = eff_dim(height_reg);
            same = (p == bg)
                || (fmt == bbt_pkg::FMT_RGBA && p[31:24] == 8'd0 && bg[31:24] == 8'd0)
                || (fmt == bbt_pkg::FMT_GRAY_ALPHA && p[15:8] == 8'd0
                    && bg[15:8] == 8'd0);
            if (!same)
            begin
                if (col < min_c) min_c = col;
                if (col > max_c) max_c = col;
                if (row < min_r) min_r = row;
                if (row > max_r) max_r = row;
                seen = 1'b1;
            end
            if (col + 1 < w)
            begin
                col = col + 1;
                return;
            end
            if (row + 1 < h)
            begin
                col = 0;
                row = row + 1;
                return;
            end
            if (seen)
            begin
                b.x = bbt_pkg::DIM_W'(min_c);
                b.y = bbt_pkg::DIM_W'(min_r);
                b.w = bbt_pkg::DIM_W'(max_c - min_c + 1);
                b.h = bbt_pkg::DIM_W'(max_r - min_r + 1);
                b.ne = 1'b1;
            end
            else
            begin
                b.x = bbt_pkg::DIM_W'(w);
                b.y = bbt_pkg::DIM_W'(h);
                b.w = '0;
                b.h = '0;
                b.ne = 1'b0;
            end
            boxes_due.push_back(b);
            restart_image();
        endfunction

        function void compare_box(box_t got);
            box_t e;
            if (boxes_due.size() == 0)
            begin
                $error("box with no image pending: x=%0d y=%0d w=%0d h=%0d nonempty=%0b",
                       got.x, got.y, got.w, got.h, got.ne);
                errors++;
                return;
            end
            e = boxes_due.pop_front();
            if (got.x !== e.x)
            begin
                $error("box_x: expected %0d, got %0d", e.x, got.x);
                errors++;
            end
            if (got.y !== e.y)
            begin
                $error("box_y: expected %0d, got %0d", e.y, got.y);
                errors++;
            end
            if (got.w !== e.w)
            begin
                $error("box_w: expected %0d, got %0d", e.w, got.w);
                errors++;
            end
            if (got.h !== e.h)
            begin
                $error("box_h: expected %0d, got %0d", e.h, got.h);
                errors++;
            end
            if (got.ne !== e.ne)
            begin
                $error("nonempty: expected %0b, got %0b", e.ne, got.ne);
                errors++;
            end
        endfunction
    endclass

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           cfg_we = 1'b0;
    bbt_pkg::cfg_reg_t              cfg_index = bbt_pkg::REG_FORMAT;
    logic [bbt_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic                           pixel_valid = 1'b0;
    logic                           pixel_stall;
    logic [bbt_pkg::PIX_W-1:0]      pixel = '0;
    logic                           box_valid;
    logic                           box_stall = 1'b0;
    logic [bbt_pkg::DIM_W-1:0]      box_x;
    logic [bbt_pkg::DIM_W-1:0]      box_y;
    logic [bbt_pkg::DIM_W-1:0]      box_w;
    logic [bbt_pkg::DIM_W-1:0]      box_h;
    logic                           nonempty;

    bounds_tracker bounds = new();
    bit no_gaps = 1'b0;
    int unsigned quiet_cycles = 0;

    pixel_bounding_box_trim_top u_top
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .pixel       (pixel),
        .box_valid   (box_valid),
        .box_stall   (box_stall),
        .box_x       (box_x),
        .box_y       (box_y),
        .box_w       (box_w),
        .box_h       (box_h),
        .nonempty    (nonempty)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int unsigned draw_wait();
        return no_gaps ? 0 : $urandom_range(0, 18);
    endfunction

    function automatic logic [bbt_pkg::PIX_W-1:0] pick_pixel(
        input logic [bbt_pkg::PIX_W-1:0] b);
        logic [bbt_pkg::PIX_W-1:0] p;
        p = $urandom();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: p = b;
            5: p[31:24] = 8'd0;
            6: p[15:8] = 8'd0;
            7: p = b ^ (32'd1 << $urandom_range(0, 31));
            default: ;
        endcase
        return p;
    endfunction

    task automatic send_pixel(input logic [bbt_pkg::PIX_W-1:0] p);
        int unsigned gap;
        gap = draw_wait();
        if (gap != 0)
        begin
            pixel_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pixel_valid <= 1'b1;
        pixel <= p;
        @(posedge clk);
        while (pixel_stall) @(posedge clk);
        bounds.take_pixel(p);
    endtask

    // Writes all four registers back to back; unused data bits are random.
    task automatic load_config(input logic [bbt_pkg::FMT_W-1:0] f,
                               input logic [bbt_pkg::PIX_W-1:0] b,
                               input logic [bbt_pkg::DIM_W-1:0] w,
                               input logic [bbt_pkg::DIM_W-1:0] h);
        bbt_pkg::cfg_reg_t idx;
        logic [bbt_pkg::CFG_DATA_W-1:0] d;
        idx = bbt_pkg::REG_FORMAT;
        do
        begin
            d = $urandom();
            case (idx)
                bbt_pkg::REG_FORMAT: d[bbt_pkg::FMT_W-1:0] = f;
                bbt_pkg::REG_REF:    d = b;
                bbt_pkg::REG_WIDTH:  d[bbt_pkg::DIM_W-1:0] = w;
                default:             d[bbt_pkg::DIM_W-1:0] = h;
            endcase
            cfg_we <= 1'b1;
            cfg_index <= idx;
            cfg_data <= d;
            @(posedge clk);
            bounds.write_reg(idx, d);
            idx = idx.next();
        end
        while (idx != bbt_pkg::REG_FORMAT);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        pixel_valid <= 1'b0;
        while (bounds.boxes_due.size() != 0) @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    initial
    begin
        int unsigned hold;
        box_t got;
        forever
        begin
            hold = draw_wait();
            if (hold != 0)
            begin
                box_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            box_stall <= 1'b0;
            @(posedge clk);
            while (box_valid !== 1'b1) @(posedge clk);
            got = '{box_x, box_y, box_w, box_h, nonempty};
            bounds.compare_box(got);
        end
    end

    always @(posedge clk)
    begin
        if ((pixel_valid && !pixel_stall) || (box_valid && !box_stall) || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        int unsigned small_items;
        int unsigned phase;
        int unsigned ew;
        int unsigned eh;
        int unsigned n;
        logic [bbt_pkg::FMT_W-1:0] f;
        logic [bbt_pkg::PIX_W-1:0] b;
        logic [bbt_pkg::DIM_W-1:0] wr;
        logic [bbt_pkg::DIM_W-1:0] hr;
        bit plain;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: 1x1 images, RGBA, background zero
        send_pixel(32'h0000_0000);
        send_pixel(32'h00FF_FFFF);
        send_pixel(32'h0100_0000);
        send_pixel(32'hFFFF_FFFF);

        wait_idle();
        load_config(bbt_pkg::FMT_GRAY_ALPHA, 32'h1234_0056, 13'd2, 13'd2);
        send_pixel(32'hABCD_00EF);
        send_pixel(32'h1234_0056);
        send_pixel(32'h1234_0156);
        send_pixel(32'h0000_0000);

        // indexed: zero alpha does not make pixels equal
        wait_idle();
        load_config(bbt_pkg::FMT_INDEXED, 32'h00FF_00FF, 13'd3, 13'd2);
        send_pixel(32'h00FF_00FF);
        send_pixel(32'h0000_00FF);
        send_pixel(32'h00FF_00FF);
        send_pixel(32'h00FF_0000);
        send_pixel(32'h00FF_00FF);
        send_pixel(32'h00FF_00FF);

        // unused format code, zero width
        wait_idle();
        load_config(FMT_UNUSED, 32'h00FF_00FF, 13'd0, 13'd2);
        send_pixel(32'h0000_0000);
        send_pixel(32'h00FF_00FF);

        wait_idle();
        load_config(bbt_pkg::FMT_RGBA, 32'h8000_0000, 13'd4, 13'd1);
        send_pixel(32'h8000_0000);
        send_pixel(32'h8000_0000);
        send_pixel(32'h0000_0000);
        send_pixel(32'h8000_0000);

        // shrink the image while the scan sits past the new last column
        wait_idle();
        load_config(bbt_pkg::FMT_RGBA, 32'h0000_0000, 13'd4, 13'd4);
        repeat (5) send_pixel(32'h0000_0000);
        send_pixel(32'hFF00_0000);
        wait_idle();
        load_config(bbt_pkg::FMT_RGBA, 32'h0000_0000, 13'd2, 13'd1);
        send_pixel(32'h0000_0000);

        small_items = 0;
        phase = 0;
        while (small_items < RANDOM_PIXELS)
        begin
            f = bbt_pkg::FMT_W'($urandom_range(0, 3));
            b = $urandom();
            case ($urandom_range(0, 3))
                0: b[31:24] = 8'd0;
                1: b[15:8] = 8'd0;
                default: ;
            endcase
            no_gaps = ($urandom_range(0, 3) == 0);
            plain = 1'b0;
            case (phase)
                2:
                begin
                    wr = 13'h1FFF;
                    hr = 13'd1;
                    no_gaps = 1'b1;
                end
                5:
                begin
                    wr = 13'd0;
                    hr = 13'd4097;
                    plain = 1'b1;
                    no_gaps = 1'b1;
                end
                8:
                begin
                    wr = 13'd4096;
                    hr = 13'd1;
                    plain = 1'b1;
                    no_gaps = 1'b1;
                end
                default:
                begin
                    wr = bbt_pkg::DIM_W'(($urandom_range(0, 9) == 0)
                                         ? $urandom_range(0, 40)
                                         : $urandom_range(1, 6));
                    hr = bbt_pkg::DIM_W'(($urandom_range(0, 9) == 0)
                                         ? $urandom_range(0, 40)
                                         : $urandom_range(1, 6));
                    plain = ($urandom_range(0, 7) == 0);
                end
            endcase
            wait_idle();
            load_config(f, b, wr, hr);
            ew = bounds_tracker::eff_dim(wr);
            eh = bounds_tracker::eff_dim(hr);
            // large images are scanned only in part; the next settings land mid-scan
            if (phase == 2 || phase == 5 || phase == 8)
                n = $urandom_range(50, 200);
            else
            begin
                n = ((ew * eh > 64) ? 1 : $urandom_range(1, 6)) * ew * eh;
                // sometimes stop mid-image so the next settings land on a partial scan
                if ($urandom_range(0, 3) == 0)
                    n = n + $urandom_range(1, ew * eh);
            end
            repeat (n) send_pixel(plain ? b : pick_pixel(b));
            small_items = small_items + n;
            phase++;
        end

        wait_idle();
        repeat (20) @(posedge clk);
        if (bounds.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// File: files.f
sv/bbt_pkg.sv
sv/bbt_cfg.sv
sv/bbt_scan.sv
sv/bbt_acc.sv
sv/pixel_bounding_box_trim_top.sv
tb/sv/tb.sv
